>>> rtl/cttd_pkg.sv
// Shared types and constants for the compact target to difficulty pipeline.
`timescale 1ns / 1ps
package cttd_pkg;

  localparam int MANT_W      = 24;
  localparam int EXP_W       = 8;
  localparam int E_W         = 12;         // signed unbiased exponent
  localparam int NUM_W       = MANT_W + 2; // partial remainder
  localparam int STEP_BITS   = 8;          // quotient bits per divider stage
  localparam int DIV_STAGES  = 7;
  localparam int QW          = STEP_BITS * DIV_STAGES;
  localparam int FRAC_W      = 52;
  localparam int SIG_W       = FRAC_W + 1;
  localparam int BEXP_W      = 11;
  localparam int GUARD_W     = QW - SIG_W; // quotient bits below the significand
  localparam int SHIFT_W     = 7;
  localparam int IDX_W       = 6;

  // One beat in flight through the divider.
  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [E_W-1:0]   e;
    logic [NUM_W-1:0]        num;
    logic [MANT_W-1:0]       den;
    logic [QW-1:0]           q;
  } div_t;

  // One beat between the align and increment stages of rounding.
  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic                    normal;
    logic [BEXP_W-1:0]       ebias;
    logic [SIG_W-1:0]        kept;
    logic                    rbit;
    logic                    sticky;
  } rnd_t;

endpackage

>>> rtl/compact_target_to_difficulty.sv
// Top level: compact target word to binary64 difficulty, fully pipelined.
`timescale 1ns / 1ps
// Takes one compact target beat per cycle and returns 65535/mantissa *
// 2^(8*(29-exponent)) as a binary64 bit pattern, rounded to nearest even with
// gradual underflow; a zero mantissa returns +0.0. The pipe has one normalize
// stage, seven divider stages of 8 quotient bits each, and two rounding stages.
// The whole pipe advances together, so throughput is one beat per cycle whenever
// out_stall is low; out_stall with out_valid high freezes every stage.
module compact_target_to_difficulty import cttd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] compact_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] difficulty_bits
);

  logic adv;
  div_t pipe [DIV_STAGES+1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  cttd_norm u_norm (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .compact_bits (compact_bits),
    .q            (pipe[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    cttd_div_stage u_stage (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (pipe[g]),
      .q   (pipe[g+1])
    );
  end

  cttd_round u_round (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .d     (pipe[DIV_STAGES]),
    .valid (out_valid),
    .bits  (difficulty_bits)
  );

endmodule

>>> rtl/cttd_norm.sv
// Input stage: split the compact word, normalize the operands, derive the exponent.
`timescale 1ns / 1ps
module cttd_norm import cttd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] compact_bits,
  output div_t        q
);

  logic [EXP_W-1:0]  expo;
  logic [MANT_W-1:0] mant;
  logic [4:0]        lz;
  logic [MANT_W-1:0] den_a;
  logic              ge;
  logic [E_W-1:0]    e_u;
  div_t              q_next;

  assign expo = compact_bits[31:24];
  assign mant = compact_bits[23:0];

  always_comb begin
    lz = '0;
    for (int i = 0; i < MANT_W; i++) begin
      if (mant[i]) lz = 5'(MANT_W - 1 - i);
    end
  end

  assign den_a = mant << lz;
  // 65535 aligned to bit 23 is 0xFFFF00
  assign ge    = 24'hFFFF00 >= den_a;
  // e = t + 8*(29 - expo), t = lz - 8 or lz - 9
  assign e_u   = {7'b0, lz} + (ge ? 12'd224 : 12'd223) - {1'b0, expo, 3'b000};

  always_comb begin
    q_next.valid = in_valid;
    q_next.zero  = (mant == '0);
    q_next.e     = $signed(e_u);
    q_next.num   = ge ? 26'h0FFFF00 : 26'h1FFFE00;
    q_next.den   = den_a;
    q_next.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

>>> rtl/cttd_div_stage.sv
// One restoring divider stage: STEP_BITS quotient bits per cycle while adv is high.
`timescale 1ns / 1ps
module cttd_div_stage import cttd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  div_t d,
  output div_t q
);

  div_t             q_next;
  logic [NUM_W-1:0] n;
  logic [QW-1:0]    qq;
  logic             b;

  always_comb begin
    n  = d.num;
    qq = d.q;
    b  = 1'b0;
    for (int i = 0; i < STEP_BITS; i++) begin
      b = n >= {2'b00, d.den};
      if (b) n = n - {2'b00, d.den};
      qq = {qq[QW-2:0], b};
      n  = {n[NUM_W-2:0], 1'b0};
    end
    q_next     = d;
    q_next.num = n;
    q_next.q   = qq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

>>> rtl/cttd_round.sv
// Two stages: align for subnormals and pick round/sticky, then increment and pack.
`timescale 1ns / 1ps
module cttd_round import cttd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  div_t        d,
  output logic        valid,
  output logic [63:0] bits
);

  logic                  normal;
  logic signed [E_W-1:0] sfull;
  logic [IDX_W-1:0]      s;
  logic [IDX_W-1:0]      idx;
  logic [SHIFT_W-1:0]    sh;
  logic [QW-1:0]         mask;
  logic [QW-1:0]         shifted;
  logic [E_W-1:0]        ebias_w;
  rnd_t                  r_next;
  rnd_t                  r;
  logic                  inc;
  logic [SIG_W:0]        qr;
  logic [63:0]           bits_next;

  assign normal  = d.e >= -12'sd1022;
  assign sfull   = -12'sd1022 - d.e;
  assign s       = normal ? '0 : sfull[IDX_W-1:0];
  assign idx     = 6'(GUARD_W - 1) + s;
  assign sh      = {1'b0, idx} + 7'd1;
  assign shifted = d.q >> sh;
  assign mask    = (56'd1 << idx) - 56'd1;
  assign ebias_w = $unsigned(d.e) + 12'd1022;

  always_comb begin
    r_next.valid  = d.valid;
    // below half the smallest subnormal everything rounds to zero
    r_next.zero   = d.zero | (!normal && sfull > 12'sd53);
    r_next.normal = normal;
    r_next.ebias  = ebias_w[BEXP_W-1:0];
    r_next.kept   = shifted[SIG_W-1:0];
    r_next.rbit   = d.q[idx];
    r_next.sticky = ((d.q & mask) != '0) || (d.num != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r.valid <= 1'b0;
    end else if (adv) begin
      r <= r_next;
    end
  end

  // carry out of the significand lands in the exponent field on its own
  assign inc = r.rbit & (r.sticky | r.kept[0]);
  assign qr  = {1'b0, r.kept} + {{SIG_W{1'b0}}, inc};

  always_comb begin
    if (r.zero) begin
      bits_next = '0;
    end else if (r.normal) begin
      bits_next = {1'b0, r.ebias, {FRAC_W{1'b0}}} + {10'b0, qr};
    end else begin
      bits_next = {10'b0, qr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= r.valid;
      bits  <= bits_next;
    end
  end

endmodule

>>> rtl/cttd_checker.sv
// Port-level checks for compact_target_to_difficulty, bound to the top level.
`timescale 1ns / 1ps
module cttd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] difficulty_bits
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(difficulty_bits))
    else $error("output beat changed while stalled");

  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output backpressure");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !difficulty_bits[63])
    else $error("negative difficulty");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind compact_target_to_difficulty cttd_checker u_cttd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .difficulty_bits (difficulty_bits)
);
